FILE: src/b32d_pkg.sv
// Shared types, constants and the character classifier for the base32 decoder.
// No dependencies.
package b32d_pkg;

    localparam int SYM_BITS       = 5;
    localparam int SYMS_PER_GROUP = 8;
    localparam int GROUP_BITS     = SYM_BITS * SYMS_PER_GROUP;
    localparam int BYTES_FULL     = 5;
    localparam int NBYTES_BITS    = 3;

    typedef enum logic [1:0] {
        CLS_SYMBOL,
        CLS_PAD,
        CLS_SKIP,
        CLS_INVALID
    } char_class_t;

    typedef struct packed {
        char_class_t          cls;
        logic [SYM_BITS-1:0]  sym;
    } char_info_t;

    // One finished group: data left aligned, with the count of bytes to emit.
    typedef struct packed {
        logic [GROUP_BITS-1:0]  data;
        logic [NBYTES_BITS-1:0] nbytes;
    } group_t;

    typedef struct packed {
        logic   valid;
        group_t group;
    } group_push_t;

    // Letters of either case share low five bits 1..26; digits '2'..'7' sit at 18..23.
    function automatic char_info_t classify(input logic [7:0] c);
        char_info_t info;
        info.cls = CLS_INVALID;
        info.sym = '0;
        case (c) inside
            [8'h41:8'h5A], [8'h61:8'h7A]:
            begin
                info.cls = CLS_SYMBOL;
                info.sym = c[4:0] - 5'd1;
            end
            [8'h32:8'h37]:
            begin
                info.cls = CLS_SYMBOL;
                info.sym = c[4:0] + 5'd8;
            end
            8'h3D:
            begin
                info.cls = CLS_PAD;
            end
            [8'h09:8'h0D], 8'h20, 8'h2D:
            begin
                info.cls = CLS_SKIP;
            end
            default:
            begin
                info.cls = CLS_INVALID;
            end
        endcase
        return info;
    endfunction

endpackage

FILE: src/b32d_front.sv
// Front end: accepts characters, classifies them and gathers symbols into groups.
// Depends on b32d_pkg.
module b32d_front
    import b32d_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  in_char,
    input  logic        end_of_string,
    input  logic        queue_space,
    output group_push_t push
);

    logic [NBYTES_BITS-1:0]             count_reg, count_next;
    logic                               halted_reg, halted_next;
    logic [SYMS_PER_GROUP-1:0][SYM_BITS-1:0] buf_reg, buf_next;
    logic [SYMS_PER_GROUP-1:0][SYM_BITS-1:0] buf_with_new;
    char_info_t                         info;
    logic                               accept;
    logic [NBYTES_BITS-1:0]             pad_bytes;

    assign in_ready = queue_space;
    assign accept   = in_valid && in_ready;
    assign info     = classify(in_char);

    // The first symbol of a group lands in the top lane, the most significant one.
    always_comb
    begin
        buf_with_new = buf_reg;
        buf_with_new[NBYTES_BITS'(SYMS_PER_GROUP - 1) - count_reg] = info.sym;
    end

    always_comb
    begin
        case (count_reg) inside
            [3'd1:3'd2]: pad_bytes = 3'd1;
            [3'd3:3'd4]: pad_bytes = 3'd2;
            3'd5:        pad_bytes = 3'd3;
            default:     pad_bytes = 3'd4;
        endcase
    end

    always_comb
    begin
        count_next  = count_reg;
        halted_next = halted_reg;
        buf_next    = buf_reg;
        push        = '0;
        if (accept)
        begin
            if (!halted_reg)
            begin
                case (info.cls)
                    CLS_SYMBOL:
                    begin
                        if (count_reg == NBYTES_BITS'(SYMS_PER_GROUP - 1))
                        begin
                            push.valid        = 1'b1;
                            push.group.data   = buf_with_new;
                            push.group.nbytes = NBYTES_BITS'(BYTES_FULL);
                            buf_next          = '0;
                            count_next        = '0;
                        end
                        else
                        begin
                            buf_next   = buf_with_new;
                            count_next = count_reg + 3'd1;
                        end
                    end
                    CLS_PAD:
                    begin
                        if (count_reg == '0)
                        begin
                            halted_next = 1'b1;
                        end
                        else
                        begin
                            push.valid        = 1'b1;
                            push.group.data   = buf_reg;
                            push.group.nbytes = pad_bytes;
                            buf_next          = '0;
                            count_next        = '0;
                        end
                    end
                    CLS_SKIP:
                    begin
                    end
                    default:
                    begin
                        halted_next = 1'b1;
                    end
                endcase
            end
            // Drop any partial group and resume decoding at the end of a string.
            if (end_of_string)
            begin
                buf_next    = '0;
                count_next  = '0;
                halted_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= '0;
            halted_reg <= 1'b0;
            buf_reg    <= '0;
        end
        else
        begin
            count_reg  <= count_next;
            halted_reg <= halted_next;
            buf_reg    <= buf_next;
        end
    end

endmodule

FILE: src/b32d_group_fifo.sv
// Short queue of finished groups between the front and back ends.
// Depends on b32d_pkg.
module b32d_group_fifo
    import b32d_pkg::*;
#(
    parameter int DEPTH = 2
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  group_push_t push,
    output logic        space,
    output logic        head_valid,
    output group_t      head,
    input  logic        pop
);

    localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_BITS = $clog2(DEPTH + 1);

    group_t                entries_reg [DEPTH];
    logic [PTR_BITS-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_BITS-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_BITS-1:0]   fill_reg, fill_next;
    logic                  do_push, do_pop;

    assign space      = (fill_reg != CNT_BITS'(DEPTH));
    assign head_valid = (fill_reg != '0);
    assign head       = entries_reg[rd_ptr_reg];
    assign do_push    = push.valid && space;
    assign do_pop     = pop && head_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_BITS'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_BITS'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            fill_next = fill_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            fill_next = fill_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entries_reg[wr_ptr_reg] <= push.group;
        end
    end

endmodule

FILE: src/b32d_back.sv
// Back end: splits queued groups into bytes, one per cycle unless out_ready stalls, into an output register.
// Depends on b32d_pkg.
module b32d_back
    import b32d_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       head_valid,
    input  group_t     head,
    output logic       pop,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] out_byte,
    output logic       group_last
);

    logic [NBYTES_BITS-1:0] idx_reg, idx_next;
    logic                   valid_reg, valid_next;
    logic [7:0]             byte_reg, byte_next;
    logic                   last_reg, last_next;
    logic                   load;
    logic                   is_last;
    logic [BYTES_FULL-1:0][7:0] group_bytes;

    assign group_bytes = head.data;
    assign load        = head_valid && (!valid_reg || out_ready);
    assign is_last     = (idx_reg + 3'd1 == head.nbytes);
    assign pop         = load && is_last;

    always_comb
    begin
        idx_next   = idx_reg;
        valid_next = valid_reg;
        byte_next  = byte_reg;
        last_next  = last_reg;
        if (load)
        begin
            valid_next = 1'b1;
            // Byte 0 is the most significant byte of the group.
            byte_next  = group_bytes[NBYTES_BITS'(BYTES_FULL - 1) - idx_reg];
            last_next  = is_last;
            idx_next   = is_last ? '0 : idx_reg + 3'd1;
        end
        else if (out_ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg   <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg   <= idx_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        byte_reg <= byte_next;
        last_reg <= last_next;
    end

    assign out_valid  = valid_reg;
    assign out_byte   = byte_reg;
    assign group_last = last_reg;

endmodule

FILE: src/base32_stream_decoder.sv
// Top level of the base32 stream decoder: front end, group queue, back end.
// Depends on b32d_pkg, b32d_front, b32d_group_fifo and b32d_back.
//
//   channel | direction | handshake             | payload
//   --------+-----------+-----------------------+------------------------------
//   input   | in        | in_valid / in_ready   | in_char, end_of_string
//   output  | out       | out_valid / out_ready | out_byte, group_last
//
// One character is taken per cycle while the group queue has space. A
// character that finishes a group (eighth symbol or a pad) enters the
// group queue in the same cycle; the back end then sends the group's bytes
// one per cycle, while out_ready allows, from its output register.
// in_ready drops only while the group queue is full; the output side may
// stall at any time without affecting accepted requests.
// Reset is asynchronous and clears the symbol count, the halt flag, the
// group buffer, the queue pointers and the output valid flag.
module base32_stream_decoder
    import b32d_pkg::*;
#(
    parameter int QUEUE_DEPTH = 2
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] in_char,
    input  logic       end_of_string,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] out_byte,
    output logic       group_last
);

    group_push_t push;
    logic        queue_space;
    logic        head_valid;
    group_t      head;
    logic        pop;

    // Classify characters and gather symbols.
    b32d_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .in_char       (in_char),
        .end_of_string (end_of_string),
        .queue_space   (queue_space),
        .push          (push)
    );

    // Hold finished groups so each side can stall on its own.
    b32d_group_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .space      (queue_space),
        .head_valid (head_valid),
        .head       (head),
        .pop        (pop)
    );

    // Emit the bytes of each group, most significant first.
    b32d_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head       (head),
        .pop        (pop),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_byte   (out_byte),
        .group_last (group_last)
    );

endmodule
